// ===== src/wrbf_pkg.sv =====
package wrbf_pkg;

  // Sizes of the width table and of the datapath words
  localparam int MAX_DIM_DEF = 64;
  localparam int TABLE_DEPTH = 64;
  localparam int TAB_AW      = 6;
  localparam int DIV_DW      = 49;
  localparam int CFG_IW      = 1;

  // Item codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_AMPLITUDE   = 1'd0;
  localparam logic [CFG_IW-1:0] REG_WIDTH_COUNT = 1'd1;

  // Multiplier operand selections
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_MAG  = 3'd1;
  localparam logic [2:0] MUL_M    = 3'd2;
  localparam logic [2:0] MUL_TERM = 3'd3;
  localparam logic [2:0] MUL_E    = 3'd4;
  localparam logic [2:0] MUL_AMP  = 3'd5;

  // Largest exponent argument, 24.0 in Q.16
  localparam logic [20:0] X_CAP = 21'd1572864;

  typedef struct packed {
    logic               func;
    logic [TAB_AW-1:0]  width_index;
    logic [15:0]        width_value;
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_elem;
  } in_t;

  typedef struct packed {
    logic [23:0] kernel_value;
    logic [6:0]  dimension;
    logic        overflow;
  } out_t;

  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       load_in;
    logic [2:0] mul_sel;
    logic       acc_elem;
    logic       drop;
    logic       div_x;
    logic       div_k;
    logic       load_x;
    logic       load_term;
    logic       clamp;
    logic       sq_step;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic full;
    logic last;
    logic div_done;
    logic k_last;
    logic sq_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== src/wrbf_ram.sv =====
module wrbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/wrbf_div.sv =====
module wrbf_div #(
  parameter int DW = 49,
  parameter int VW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quo,
  output logic          done
);

  localparam int NW = $clog2(DW + 1);

  logic [VW-1:0] dvs;
  logic [VW-1:0] rem;
  logic [NW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;
  logic          ge;
  logic [VW-1:0] rem_next;
  logic [VW:0]   diff;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    trial    = {rem, quo[DW-1]};
    ge       = trial >= {1'b0, dvs};
    diff     = trial - {1'b0, dvs};
    rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DW-2:0], ge};
        rem <= rem_next;
        cnt <= cnt + NW'(1);
        if (cnt == NW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/wrbf_dp.sv =====
module wrbf_dp #(
  parameter int MAX_DIM = wrbf_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wrbf_pkg::in_t               in_data,
  input  logic                        cfg_we,
  input  logic [wrbf_pkg::CFG_IW-1:0] cfg_index,
  input  logic [15:0]                 cfg_wdata,
  input  wrbf_pkg::cmd_t              cmd,
  output wrbf_pkg::stat_t             stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output wrbf_pkg::out_t              out_data
);
  import wrbf_pkg::*;

  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int EW = (CW > 7) ? CW : 7;
  localparam int VW = (CW + 1 > 3) ? CW + 1 : 3;

  logic [15:0]        amplitude;
  logic [6:0]         width_count;
  logic signed [15:0] elem_a;
  logic signed [15:0] elem_b;
  logic               last;
  logic [47:0]        square_sum;
  logic [CW-1:0]      element_count;
  logic               overflow_seen;
  logic [63:0]        prod;
  logic [26:0]        r;
  logic [31:0]        term;
  logic signed [34:0] acc;
  logic [2:0]         k;
  logic [31:0]        e;
  logic [3:0]         sq_cnt;

  logic [EW-1:0]       count_ext;
  logic [TAB_AW-1:0]   rd_addr;
  logic [15:0]         rd_w;
  logic signed [16:0]  diff;
  logic [16:0]         neg_diff;
  logic [15:0]         mag;
  logic [33:0]         rnd_m;
  logic [63:0]         rnd_t;
  logic [63:0]         rnd_e;
  logic [63:0]         rnd_k;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [48:0]         sum_add;
  logic [CW-1:0]       count_d;
  logic [DIV_DW-1:0]   div_dividend;
  logic [VW-1:0]       div_divisor;
  logic [DIV_DW-1:0]   quo;
  logic                div_done;
  logic [20:0]         xq;
  logic [35:0]         r_full;
  logic signed [34:0]  term_ext;

  // Width table
  assign count_ext = EW'(element_count);
  assign rd_addr = (count_ext < EW'(width_count) && count_ext < EW'(TABLE_DEPTH))
                   ? count_ext[TAB_AW-1:0] : '0;

  wrbf_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(in_data.width_index),
    .wdata(in_data.width_value),
    .re   (cmd.rd),
    .raddr(rd_addr),
    .rdata(rd_w)
  );

  // Shared divider: distance scaling and the series terms
  assign count_d      = (element_count == '0) ? CW'(1) : element_count;
  assign div_dividend = cmd.div_x ? ({1'b0, square_sum} + DIV_DW'(count_d))
                                  : DIV_DW'(rnd_t[63:31]);
  assign div_divisor  = cmd.div_x ? VW'({count_d, 1'b0}) : VW'(k);

  wrbf_div #(
    .DW(DIV_DW),
    .VW(VW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_x | cmd.div_k),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quo     (quo),
    .done    (div_done)
  );

  // Element arithmetic and rounding of products
  always_comb begin
    diff     = {elem_a[15], elem_a} - {elem_b[15], elem_b};
    neg_diff = -diff;
    mag      = diff[16] ? neg_diff[15:0] : diff[15:0];
    rnd_m    = prod[33:0] + 34'd2048;
    rnd_t    = prod + 64'h4000_0000;
    rnd_e    = prod + 64'h4000_0000;
    rnd_k    = prod + 64'h40_0000;
    sum_add  = {1'b0, square_sum} + 49'(prod[41:0]);
    xq       = (quo > DIV_DW'(X_CAP)) ? X_CAP : quo[20:0];
    r_full   = {xq, 15'd0} + 36'd256;
    term_ext = 35'(quo[31:0]);
  end

  // Multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_MAG: begin
        mul_a = 32'(mag);
        mul_b = 32'(rd_w);
      end
      MUL_M: begin
        mul_a = 32'(rnd_m[32:12]);
        mul_b = 32'(rnd_m[32:12]);
      end
      MUL_TERM: begin
        mul_a = term;
        mul_b = 32'(r);
      end
      MUL_E: begin
        mul_a = e;
        mul_b = e;
      end
      MUL_AMP: begin
        mul_a = 32'(amplitude);
        mul_b = e;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude   <= 16'd256;
      width_count <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AMPLITUDE:   amplitude   <= cfg_wdata;
        REG_WIDTH_COUNT: width_count <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Hold the element pair under work
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      elem_a <= in_data.elem_a;
      elem_b <= in_data.elem_b;
      last   <= in_data.last_elem;
    end
  end

  // Accumulator, pair count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      element_count <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.load_out) begin
      square_sum    <= '0;
      element_count <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.acc_elem) begin
      element_count <= element_count + CW'(1);
      if (sum_add[48]) begin
        square_sum    <= '1;
        overflow_seen <= 1'b1;
      end else begin
        square_sum <= sum_add[47:0];
      end
    end else if (cmd.drop) begin
      overflow_seen <= 1'b1;
    end
  end

  // Series for exp(-x/512), then nine squarings
  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      r    <= r_full[35:9];
      term <= 32'h8000_0000;
      acc  <= 35'sh0_8000_0000;
      k    <= 3'd1;
    end else if (cmd.load_term) begin
      term <= quo[31:0];
      acc  <= k[0] ? acc - term_ext : acc + term_ext;
      k    <= k + 3'd1;
    end
    if (cmd.clamp) begin
      if (acc < 0) begin
        e <= '0;
      end else if (acc > 35'sh0_8000_0000) begin
        e <= 32'h8000_0000;
      end else begin
        e <= acc[31:0];
      end
      sq_cnt <= '0;
    end else if (cmd.sq_step) begin
      e      <= rnd_e[62:31];
      sq_cnt <= sq_cnt + 4'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.kernel_value <= rnd_k[46:23];
      out_data.dimension    <= count_ext[6:0];
      out_data.overflow     <= overflow_seen;
    end
  end

  // Status to the controller
  always_comb begin
    stat.func     = in_data.func;
    stat.full     = element_count == CW'(MAX_DIM);
    stat.last     = last;
    stat.div_done = div_done;
    stat.k_last   = k == 3'd6;
    stat.sq_last  = sq_cnt == 4'd8;
    stat.out_busy = out_valid && out_stall;
  end

endmodule

// ===== src/wrbf_ctrl.sv =====
module wrbf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  wrbf_pkg::stat_t stat,
  output wrbf_pkg::cmd_t  cmd
);
  import wrbf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAG    = 4'd1;
  localparam logic [3:0] S_SQ     = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_XSTART = 4'd4;
  localparam logic [3:0] S_XWAIT  = 4'd5;
  localparam logic [3:0] S_TMUL   = 4'd6;
  localparam logic [3:0] S_TSTART = 4'd7;
  localparam logic [3:0] S_TWAIT  = 4'd8;
  localparam logic [3:0] S_CLAMP  = 4'd9;
  localparam logic [3:0] S_SQR    = 4'd10;
  localparam logic [3:0] S_SQW    = 4'd11;
  localparam logic [3:0] S_AMP    = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && state == S_IDLE;

  // Sequence one item
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.wr      = accept && stat.func == FUNC_LOAD;
        cmd.rd      = accept && stat.func == FUNC_DATA;
        cmd.load_in = accept && stat.func == FUNC_DATA;
        if (accept && stat.func == FUNC_DATA) begin
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        if (stat.full) begin
          cmd.drop   = 1'b1;
          state_next = stat.last ? S_XSTART : S_IDLE;
        end else begin
          cmd.mul_sel = MUL_MAG;
          state_next  = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_sel = MUL_M;
        state_next  = S_ACC;
      end
      S_ACC: begin
        cmd.acc_elem = 1'b1;
        state_next   = stat.last ? S_XSTART : S_IDLE;
      end
      S_XSTART: begin
        cmd.div_x  = 1'b1;
        state_next = S_XWAIT;
      end
      S_XWAIT: begin
        if (stat.div_done) begin
          cmd.load_x = 1'b1;
          state_next = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.mul_sel = MUL_TERM;
        state_next  = S_TSTART;
      end
      S_TSTART: begin
        cmd.div_k  = 1'b1;
        state_next = S_TWAIT;
      end
      S_TWAIT: begin
        if (stat.div_done) begin
          cmd.load_term = 1'b1;
          state_next    = stat.k_last ? S_CLAMP : S_TMUL;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_SQR;
      end
      S_SQR: begin
        cmd.mul_sel = MUL_E;
        state_next  = S_SQW;
      end
      S_SQW: begin
        cmd.sq_step = 1'b1;
        state_next  = stat.sq_last ? S_AMP : S_SQR;
      end
      S_AMP: begin
        cmd.mul_sel = MUL_AMP;
        state_next  = S_OUT;
      end
      S_OUT: begin
        cmd.mul_sel = MUL_AMP;
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/weighted_rbf_kernel_top.sv =====
// Weighted Gaussian RBF kernel. Width table entries (func 0) are written as
// accepted. An element pair (func 1) takes a table read, the scaled difference
// product, its square and the accumulate, all on one shared 32x32 multiplier,
// or is dropped as overflow once MAX_DIM pairs are held. A pair marked last
// then evaluates the kernel before the result is registered: the bit-serial
// divider runs seven times (one for the distance over 2d, six for the series
// terms), followed by nine squarings on the multiplier. The result waits in an
// output register, and the next vector's pairs are taken while it waits.
module weighted_rbf_kernel_top #(
  parameter int MAX_DIM = wrbf_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  wrbf_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output wrbf_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [wrbf_pkg::CFG_IW-1:0] cfg_index,
  input  logic [15:0]                 cfg_wdata
);
  import wrbf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  wrbf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  wrbf_dp #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // An element pair always occupies the block past its transfer
  a_pair_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.func == FUNC_DATA) |=> in_stall)
    else $error("element pair did not hold off the input");

  // A table load completes in its own cycle
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.func == FUNC_LOAD) |=> !in_stall)
    else $error("table load held off the input");

  // A result only appears at the end of work on a closing pair
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule
